FILE: src/assert_macros.svh
// assertion helpers for the hole fill block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define VHF_ASSERT_IMP(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error("violated");
`define VHF_ASSERT_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error("violated");
`else
`define VHF_ASSERT_IMP(label, clk, rst_n, a, c)
`define VHF_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

FILE: src/vhf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vhf_pkg
// Types and constants shared by the volume hole fill block.
// ----------------------------------------------------------------------------
package vhf_pkg;
	localparam int unsigned DefMaxX = 64;
	localparam int unsigned DefMaxY = 64;
	localparam int unsigned DefMaxZ = 64;
	localparam int unsigned CfgW    = 16;
	localparam int unsigned CfgIdxW = 3;

	localparam logic [1:0] OP_LOAD = 2'd0;
	localparam logic [1:0] OP_FILL = 2'd1;
	localparam logic [1:0] OP_READ = 2'd2;
	localparam logic [1:0] OP_NOP  = 2'd3;

	localparam logic [CfgIdxW-1:0] REG_SIZE_X = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_SIZE_Y = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_SIZE_Z = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_FORMAT = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_SCALE  = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_THRESH = 3'd5;

	localparam logic KIND_READ = 1'b0;
	localparam logic KIND_FILL = 1'b1;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [5:0]  pos_x;
		logic [5:0]  pos_y;
		logic [5:0]  pos_z;
		logic [15:0] sample;
	} in_item_t;

	typedef struct packed {
		logic       result_kind;
		logic [7:0] mask_value;
		logic       box_empty;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_MUL, ST_CONV, ST_RD_WAIT, ST_FILL_CTR, ST_SCAN, ST_SCAN_WAIT,
		ST_NEXT, ST_OUT
	} state_t;

	// scan phase: which line is being searched for the current voxel
	typedef enum logic [2:0] {
		PH_CTR, PH_XL, PH_XH, PH_YL, PH_YH, PH_ZL, PH_ZH
	} phase_t;

	// 32-bit product / 65792 by reciprocal; product below 2^32
	function automatic logic [7:0] div_sat(input logic [31:0] p);
		logic [31:0] q;
		logic [63:0] m;
		begin
			m = {32'd0, p} * 64'd65281;
			q = m[63:32];
			if ({32'd0, q} * 64'd65792 + 64'd65792 <= {32'd0, p}) q = q + 32'd1;
			div_sat = (q > 32'd255) ? 8'd255 : q[7:0];
		end
	endfunction
endpackage

FILE: src/vhf_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vhf_mem
// Single-port one-bit voxel store with registered read data.
// ----------------------------------------------------------------------------
module vhf_mem #(
	parameter int unsigned AW = 18
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] addr,
	input  logic          wdata,
	output logic          rdata
);
	logic mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

FILE: src/vhf_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vhf_mul
// Registered sample by scale multiplier feeding the byte conversion.
// ----------------------------------------------------------------------------
module vhf_mul (
	input  logic        clk,
	input  logic [15:0] a,
	input  logic [15:0] b,
	output logic [31:0] p_q
);
	always_ff @(posedge clk) begin
		p_q <= a * b;
	end
endmodule

FILE: src/volume_hole_fill.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// volume_hole_fill
// Mask builder with bounding-box hole filling over a one-bit voxel store.
// ----------------------------------------------------------------------------
// Use: write registers on cfg_we/cfg_index/cfg_data while idle. Items enter
// on in_valid/in_stall (opcode load, fill or read) and results leave on
// out_valid/out_stall. A load passes through the multiply and convert states
// and gives no result; a read waits for the registered data and then for the
// receiver. A fill walks the box one voxel at a time; each clear voxel scans
// its x window, y window and z line through the single memory port, one voxel
// read at a time (address, then registered data). A fill of an empty box
// goes to the output state, which then registers its result. in_stall is
// high while an item is in work; a result waits in the output register while
// out_stall is high. Reset clears the box record and the control state; the
// store itself holds nothing valid until loaded.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module volume_hole_fill #(
	parameter int unsigned MAX_X = vhf_pkg::DefMaxX,
	parameter int unsigned MAX_Y = vhf_pkg::DefMaxY,
	parameter int unsigned MAX_Z = vhf_pkg::DefMaxZ
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [vhf_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [vhf_pkg::CfgW-1:0]     cfg_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  vhf_pkg::in_item_t            in_item,
	output logic                         out_valid,
	input  logic                         out_stall,
	output vhf_pkg::out_item_t           out_item
);
	localparam int unsigned XW = $clog2(MAX_X);
	localparam int unsigned YW = $clog2(MAX_Y);
	localparam int unsigned ZW = $clog2(MAX_Z);
	localparam int unsigned AW = XW + YW + ZW;

	vhf_pkg::state_t st_q, st_d;
	vhf_pkg::phase_t ph_q, ph_d;

	logic [6:0]  size_x_q, size_y_q, size_z_q;
	logic        fmt_q;
	logic [15:0] scale_q;
	logic [7:0]  thr_q;

	logic [5:0] bminx_q, bminy_q, bminz_q, bmaxx_q, bmaxy_q, bmaxz_q;
	logic       bvalid_q;

	vhf_pkg::in_item_t it_q;
	logic [5:0] i_q, j_q, k_q, t_q;
	logic [5:0] i_d, j_d, k_d, t_d;
	logic [5:0] hi_q, hi_d;

	logic        mem_we;
	logic [AW-1:0] mem_addr;
	logic        mem_wd, mem_rd;
	logic [31:0] prod;

	vhf_pkg::out_item_t out_q, out_d;
	logic ov_q, ov_d;

	// hold config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q <= 7'd64; size_y_q <= 7'd64; size_z_q <= 7'd64;
			fmt_q <= 1'b0; scale_q <= 16'd256; thr_q <= 8'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				vhf_pkg::REG_SIZE_X: size_x_q <= cfg_data[6:0];
				vhf_pkg::REG_SIZE_Y: size_y_q <= cfg_data[6:0];
				vhf_pkg::REG_SIZE_Z: size_z_q <= cfg_data[6:0];
				vhf_pkg::REG_FORMAT: fmt_q <= cfg_data[0];
				vhf_pkg::REG_SCALE:  scale_q <= cfg_data;
				vhf_pkg::REG_THRESH: thr_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// effective sizes: zero acts as one, above the store acts as the store
	function automatic logic [10:0] eff(input logic [6:0] v, input int unsigned m);
		logic [10:0] r;
		begin
			r = {4'd0, v};
			if (v == 7'd0) r = 11'd1;
			if ({4'd0, v} > 11'(m)) r = 11'(m);
			eff = r;
		end
	endfunction

	logic in_vol;
	assign in_vol = ({5'd0, it_q.pos_x} < eff(size_x_q, MAX_X)) &&
		({5'd0, it_q.pos_y} < eff(size_y_q, MAX_Y)) &&
		({5'd0, it_q.pos_z} < eff(size_z_q, MAX_Z));

	function automatic logic [AW-1:0] addr_of(input logic [5:0] x, input logic [5:0] y,
		input logic [5:0] z);
		logic [15:0] xx, yy, zz;
		begin
			xx = {10'd0, x}; yy = {10'd0, y}; zz = {10'd0, z};
			addr_of = {zz[ZW-1:0], yy[YW-1:0], xx[XW-1:0]};
		end
	endfunction

	vhf_mem #(.AW(AW)) u_mem (
		.clk(clk), .we(mem_we), .addr(mem_addr), .wdata(mem_wd), .rdata(mem_rd)
	);

	vhf_mul u_mul (.clk(clk), .a(it_q.sample), .b(scale_q), .p_q(prod));

	logic [7:0] byte_v;
	logic       set_v;
	assign byte_v = fmt_q ? vhf_pkg::div_sat(prod) : it_q.sample[7:0];
	assign set_v = byte_v > thr_q;

	// scan window bounds for the current voxel
	logic [6:0] wx, wy, xlo, xhi, ylo, yhi;
	always_comb begin
		wx = {1'b0, bmaxx_q} - {1'b0, bminx_q};
		wy = {1'b0, bmaxy_q} - {1'b0, bminy_q};
		xlo = {1'b0, i_q} - ((wx + 7'd1) >> 1);
		if ({1'b0, i_q} < ((wx + 7'd1) >> 1) || xlo < {1'b0, bminx_q}) xlo = {1'b0, bminx_q};
		xhi = {1'b0, i_q} + (wx >> 1);
		if (xhi > {1'b0, bmaxx_q}) xhi = {1'b0, bmaxx_q};
		ylo = {1'b0, j_q} - ((wy + 7'd1) >> 1);
		if ({1'b0, j_q} < ((wy + 7'd1) >> 1) || ylo < {1'b0, bminy_q}) ylo = {1'b0, bminy_q};
		yhi = {1'b0, j_q} + (wy >> 1);
		if (yhi > {1'b0, bmaxy_q}) yhi = {1'b0, bmaxy_q};
	end

	// next state and memory control
	always_comb begin
		st_d = st_q; ph_d = ph_q;
		i_d = i_q; j_d = j_q; k_d = k_q; t_d = t_q; hi_d = hi_q;
		mem_we = 1'b0; mem_wd = 1'b0;
		mem_addr = addr_of(it_q.pos_x, it_q.pos_y, it_q.pos_z);
		out_d = out_q; ov_d = ov_q;
		if (ov_q && !out_stall) ov_d = 1'b0;
		case (st_q)
			vhf_pkg::ST_IDLE: begin
				if (in_valid) begin
					case (in_item.opcode)
						vhf_pkg::OP_LOAD: st_d = vhf_pkg::ST_MUL;
						vhf_pkg::OP_READ: st_d = vhf_pkg::ST_RD_WAIT;
						vhf_pkg::OP_FILL: begin
							i_d = bminx_q; j_d = bminy_q; k_d = bminz_q;
							st_d = bvalid_q ? vhf_pkg::ST_FILL_CTR : vhf_pkg::ST_OUT;
						end
						default: ;
					endcase
				end
			end
			// wait for the registered product of the new sample
			vhf_pkg::ST_MUL: st_d = vhf_pkg::ST_CONV;
			vhf_pkg::ST_CONV: begin
				// drop loads outside the volume
				mem_we = in_vol; mem_wd = set_v;
				st_d = vhf_pkg::ST_IDLE;
			end
			vhf_pkg::ST_RD_WAIT: st_d = vhf_pkg::ST_SCAN_WAIT;
			vhf_pkg::ST_FILL_CTR: begin
				mem_addr = addr_of(i_q, j_q, k_q);
				ph_d = vhf_pkg::PH_CTR;
				st_d = vhf_pkg::ST_SCAN;
			end
			vhf_pkg::ST_SCAN: begin
				// issue one memory read; its registered data is used in the wait state
				case (ph_q)
					vhf_pkg::PH_XL, vhf_pkg::PH_XH: mem_addr = addr_of(t_q, j_q, k_q);
					vhf_pkg::PH_YL, vhf_pkg::PH_YH: mem_addr = addr_of(i_q, t_q, k_q);
					vhf_pkg::PH_ZL, vhf_pkg::PH_ZH: mem_addr = addr_of(i_q, j_q, t_q);
					default: mem_addr = addr_of(i_q, j_q, k_q);
				endcase
				st_d = vhf_pkg::ST_SCAN_WAIT;
			end
			vhf_pkg::ST_SCAN_WAIT: begin
				if (it_q.opcode == vhf_pkg::OP_READ) begin
					out_d = '{vhf_pkg::KIND_READ, (in_vol && mem_rd) ? 8'hFF : 8'h00, 1'b0};
					ov_d = 1'b1;
					st_d = vhf_pkg::ST_OUT;
				end else begin
					st_d = vhf_pkg::ST_SCAN;
					case (ph_q)
						vhf_pkg::PH_CTR: begin
							if (mem_rd) st_d = vhf_pkg::ST_NEXT;
							else begin ph_d = vhf_pkg::PH_XL; t_d = xlo[5:0]; hi_d = i_q; end
						end
						vhf_pkg::PH_XL, vhf_pkg::PH_YL, vhf_pkg::PH_ZL,
						vhf_pkg::PH_XH, vhf_pkg::PH_YH, vhf_pkg::PH_ZH: begin
							if (mem_rd) begin
								case (ph_q)
									vhf_pkg::PH_XL: begin
										ph_d = vhf_pkg::PH_XH; t_d = i_q; hi_d = xhi[5:0];
									end
									vhf_pkg::PH_XH: begin
										ph_d = vhf_pkg::PH_YL; t_d = ylo[5:0]; hi_d = j_q;
									end
									vhf_pkg::PH_YL: begin
										ph_d = vhf_pkg::PH_YH; t_d = j_q; hi_d = yhi[5:0];
									end
									vhf_pkg::PH_YH: begin
										ph_d = vhf_pkg::PH_ZL; t_d = bminz_q; hi_d = k_q;
									end
									vhf_pkg::PH_ZL: begin
										ph_d = vhf_pkg::PH_ZH; t_d = k_q; hi_d = bmaxz_q;
									end
									default: begin
										// all six searches hit: set the voxel
										mem_we = 1'b1; mem_wd = 1'b1;
										mem_addr = addr_of(i_q, j_q, k_q);
										st_d = vhf_pkg::ST_NEXT;
									end
								endcase
							end else if (t_q == hi_q) begin
								st_d = vhf_pkg::ST_NEXT;
							end else begin
								t_d = t_q + 6'd1;
							end
						end
						default: st_d = vhf_pkg::ST_NEXT;
					endcase
				end
			end
			vhf_pkg::ST_NEXT: begin
				// advance z innermost, then y, then x
				st_d = vhf_pkg::ST_FILL_CTR;
				if (k_q != bmaxz_q) k_d = k_q + 6'd1;
				else begin
					k_d = bminz_q;
					if (j_q != bmaxy_q) j_d = j_q + 6'd1;
					else begin
						j_d = bminy_q;
						if (i_q != bmaxx_q) i_d = i_q + 6'd1;
						else st_d = vhf_pkg::ST_OUT;
					end
				end
				if (st_d == vhf_pkg::ST_OUT) begin
					out_d = '{vhf_pkg::KIND_FILL, 8'h00, 1'b0};
					ov_d = 1'b1;
				end
			end
			vhf_pkg::ST_OUT: begin
				if (it_q.opcode == vhf_pkg::OP_FILL && !bvalid_q && !ov_q) begin
					out_d = '{vhf_pkg::KIND_FILL, 8'h00, 1'b1};
					ov_d = 1'b1;
				end
				// hold until the result is taken
				if (ov_q && !out_stall) st_d = vhf_pkg::ST_IDLE;
			end
			default: st_d = vhf_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= vhf_pkg::ST_IDLE; ph_q <= vhf_pkg::PH_CTR; ov_q <= 1'b0;
			bminx_q <= 6'd63; bminy_q <= 6'd63; bminz_q <= 6'd63;
			bmaxx_q <= 6'd0; bmaxy_q <= 6'd0; bmaxz_q <= 6'd0;
			bvalid_q <= 1'b0;
		end else begin
			st_q <= st_d; ph_q <= ph_d; ov_q <= ov_d;
			if (st_q == vhf_pkg::ST_CONV && in_vol && set_v) begin
				bvalid_q <= 1'b1;
				if (!bvalid_q || it_q.pos_x < bminx_q) bminx_q <= it_q.pos_x;
				if (!bvalid_q || it_q.pos_y < bminy_q) bminy_q <= it_q.pos_y;
				if (!bvalid_q || it_q.pos_z < bminz_q) bminz_q <= it_q.pos_z;
				if (!bvalid_q || it_q.pos_x > bmaxx_q) bmaxx_q <= it_q.pos_x;
				if (!bvalid_q || it_q.pos_y > bmaxy_q) bmaxy_q <= it_q.pos_y;
				if (!bvalid_q || it_q.pos_z > bmaxz_q) bmaxz_q <= it_q.pos_z;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == vhf_pkg::ST_IDLE && in_valid) it_q <= in_item;
		i_q <= i_d; j_q <= j_d; k_q <= k_d; t_q <= t_d; hi_q <= hi_d;
		out_q <= out_d;
	end

	assign in_stall = (st_q != vhf_pkg::ST_IDLE);
	assign out_valid = ov_q;
	assign out_item = out_q;

	`VHF_ASSERT_IMP(a_busy_no_take, clk, arst_n, out_valid, in_stall)
	`VHF_ASSERT_NEXT(a_out_from_idle, clk, arst_n, out_valid && !out_stall, !out_valid)
	`VHF_ASSERT_IMP(a_box_order, clk, arst_n, bvalid_q, bminx_q <= bmaxx_q && bminz_q <= bmaxz_q)
endmodule
